@@ design/mau_pkg.sv @@
// Shared types and command codes of the modular arithmetic unit.
// No dependencies.
`timescale 1ns / 1ps

package mau_pkg;

    localparam logic [1:0] CMD_GCD = 2'd0;
    localparam logic [1:0] CMD_INV = 2'd1;
    localparam logic [1:0] CMD_POW = 2'd2;

    // divider request: start pulse, half selects a short (one operand wide) dividend
    typedef struct packed {
        logic start;
        logic half;
    } t_div_ctl;

endpackage

@@ design/mau_divider.sv @@
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on mau_pkg.
`timescale 1ns / 1ps

module mau_divider
    import mau_pkg::*;
#(
    parameter int W = 31
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_ctl         i_ctl,
    input  logic [2*W-1:0]   i_num,
    input  logic [W-1:0]     i_den,
    output logic             o_done,
    output logic [2*W-1:0]   o_quo,
    output logic [W-1:0]     o_rem
);

    localparam int CW = $clog2(2*W+1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W:0]    r_rem;
    logic [2*W-1:0] r_quo;
    logic [W-1:0]  r_den;

    logic [W:0]    rem_sh;
    logic [W:0]    diff;
    logic          ge;

    assign rem_sh = {r_rem[W-1:0], r_quo[2*W-1]};
    assign ge     = rem_sh >= {1'b0, r_den};
    assign diff   = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.half ? CW'(W) : CW'(2*W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_ctl.half ? {i_num[W-1:0], {W{1'b0}}} : i_num;
        end else if (r_busy) begin
            r_rem <= ge ? diff : rem_sh;
            r_quo <= {r_quo[2*W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem[W-1:0];

endmodule

@@ design/mau_multiplier.sv @@
// Registered unsigned multiplier shared by power and inverse steps.
// No dependencies.
`timescale 1ns / 1ps

module mau_multiplier #(
    parameter int W = 31
) (
    input  logic             i_clk,
    input  logic [W-1:0]     i_a,
    input  logic [W:0]       i_b,
    output logic [2*W:0]     o_prod
);

    logic [2*W:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= (2*W+1)'(i_a) * (2*W+1)'(i_b);
    end

    assign o_prod = r_prod;

endmodule

@@ design/modular_arithmetic_unit.sv @@
// Modular arithmetic unit: gcd, modular inverse and modular power on one
// bit-serial divider and one registered multiplier under a sequencer (W = OPERAND_WIDTH).
// Paced by the divider, one quotient bit per cycle: gcd divides once per remainder step,
// inverse divide and multiply per Euclid step; power square per bit, multiply per set bit.
// Throughput: one item at a time, busy high until the result strobe; no stall.
// Reset: synchronous active-low i_rst_n returns the sequencer to idle.
`timescale 1ns / 1ps

module modular_arithmetic_unit
    import mau_pkg::*;
#(
    parameter int OPERAND_WIDTH  = 31,
    parameter int EXPONENT_WIDTH = 63
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_command,
    input  logic [OPERAND_WIDTH-1:0]  i_value_a,
    input  logic [OPERAND_WIDTH-1:0]  i_value_b,
    input  logic [EXPONENT_WIDTH-1:0] i_exponent,
    input  logic [OPERAND_WIDTH-1:0]  i_modulus,
    output logic                      o_result_valid,
    output logic [OPERAND_WIDTH-1:0]  o_result
);

    localparam int W  = OPERAND_WIDTH;
    localparam int E  = EXPONENT_WIDTH;
    localparam int SW = W + 2;   // signed Bezout coefficient width

    // sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_GCD     = 4'd1;   // wait remainder a % b
    localparam logic [3:0] S_INV_CHK = 4'd2;
    localparam logic [3:0] S_INV_DIV = 4'd3;
    localparam logic [3:0] S_INV_MUL = 4'd4;
    localparam logic [3:0] S_INV_UPD = 4'd5;
    localparam logic [3:0] S_PW_CHK  = 4'd6;
    localparam logic [3:0] S_PW_AMUL = 4'd7;
    localparam logic [3:0] S_PW_ARED = 4'd8;
    localparam logic [3:0] S_PW_AWT  = 4'd9;
    localparam logic [3:0] S_PW_SMUL = 4'd10;
    localparam logic [3:0] S_PW_SRED = 4'd11;
    localparam logic [3:0] S_PW_SWT  = 4'd12;

    logic [3:0]          r_state, n_state;
    logic [W-1:0]        r_x, n_x;       // gcd a / previous remainder / accumulator
    logic [W-1:0]        r_y, n_y;       // gcd b / current remainder / base
    logic [W-1:0]        r_m, n_m;
    logic [W-1:0]        r_q, n_q;
    logic [W-1:0]        r_nr, n_nr;
    logic [E-1:0]        r_e, n_e;
    logic signed [SW-1:0] r_cp, n_cp;
    logic signed [SW-1:0] r_cc, n_cc;
    logic [W-1:0]        r_result, n_result;
    logic                r_valid, n_valid;
    t_div_ctl            r_div, n_div;
    logic [2*W-1:0]      r_num, n_num;
    logic [W-1:0]        r_den, n_den;

    logic                div_done;
    logic [2*W-1:0]      div_quo;
    logic [W-1:0]        div_rem;
    logic [W-1:0]        mul_a;
    logic [W:0]          mul_b;
    logic [2*W:0]        mul_p;

    logic [SW-1:0]       cc_mag;
    logic [SW-1:0]       cp_mag;
    logic [SW-1:0]       cp_red;
    logic [W-1:0]        inv_res;
    logic [SW-1:0]       prod_s;

    mau_divider #(.W(W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_div),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    mau_multiplier #(.W(W)) u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_p)
    );

    // |coefficients| never exceed the modulus
    assign cc_mag = r_cc[SW-1] ? SW'(-r_cc) : SW'(r_cc);
    assign cp_mag = r_cp[SW-1] ? SW'(-r_cp) : SW'(r_cp);
    assign cp_red = (cp_mag >= SW'(r_m)) ? cp_mag - SW'(r_m) : cp_mag;
    // truncating remainder, then fold negatives into [0, m)
    assign inv_res = (r_cp[SW-1] && cp_red != '0) ? r_m - cp_red[W-1:0] : cp_red[W-1:0];
    assign prod_s  = mul_p[SW-1:0];

    always_comb begin
        if (r_state == S_INV_MUL) begin
            mul_a = r_q;
            mul_b = cc_mag[W:0];
        end else if (r_state == S_PW_AMUL) begin
            mul_a = r_x;
            mul_b = {1'b0, r_y};
        end else begin
            mul_a = r_y;
            mul_b = {1'b0, r_y};
        end
    end

    always_comb begin
        n_state  = r_state;
        n_x      = r_x;
        n_y      = r_y;
        n_m      = r_m;
        n_q      = r_q;
        n_nr     = r_nr;
        n_e      = r_e;
        n_cp     = r_cp;
        n_cc     = r_cc;
        n_result = r_result;
        n_valid  = 1'b0;
        n_div    = '0;
        n_num    = r_num;
        n_den    = r_den;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_x  = i_value_a;
                    n_y  = i_value_b;
                    n_m  = i_modulus;
                    n_e  = i_exponent;
                    n_cp = '0;
                    n_cc = SW'(1);
                    unique case (i_command)
                        CMD_GCD: begin
                            if (i_value_b == '0) begin
                                n_result = i_value_a;
                                n_valid  = 1'b1;
                            end else begin
                                n_div.start = 1'b1;
                                n_div.half  = 1'b1;
                                n_num = {{W{1'b0}}, i_value_a};
                                n_den = i_value_b;
                                n_state = S_GCD;
                            end
                        end
                        CMD_INV: begin
                            n_x = i_modulus;
                            n_y = i_value_a;
                            if (i_modulus == '0) begin
                                n_result = '0;
                                n_valid  = 1'b1;
                            end else begin
                                n_state = S_INV_CHK;
                            end
                        end
                        CMD_POW: begin
                            n_x = W'(1);
                            n_y = i_value_a;
                            if (i_modulus == '0) begin
                                n_result = '0;
                                n_valid  = 1'b1;
                            end else begin
                                n_state = S_PW_CHK;
                            end
                        end
                        default: begin
                            n_result = '0;
                            n_valid  = 1'b1;
                        end
                    endcase
                end
            end
            S_GCD: begin
                if (div_done) begin
                    n_x = r_y;
                    n_y = div_rem;
                    if (div_rem == '0) begin
                        n_result = r_y;
                        n_valid  = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_div.start = 1'b1;
                        n_div.half  = 1'b1;
                        n_num = {{W{1'b0}}, r_y};
                        n_den = div_rem;
                    end
                end
            end
            S_INV_CHK: begin
                if (r_y != '0) begin
                    n_div.start = 1'b1;
                    n_div.half  = 1'b1;
                    n_num = {{W{1'b0}}, r_x};
                    n_den = r_y;
                    n_state = S_INV_DIV;
                end else begin
                    n_result = inv_res;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_INV_DIV: begin
                if (div_done) begin
                    n_q  = div_quo[W-1:0];
                    n_nr = div_rem;
                    n_state = S_INV_MUL;
                end
            end
            S_INV_MUL: begin
                n_state = S_INV_UPD;
            end
            S_INV_UPD: begin
                n_x  = r_y;
                n_y  = r_nr;
                n_cp = r_cc;
                n_cc = r_cc[SW-1] ? r_cp + $signed(prod_s) : r_cp - $signed(prod_s);
                n_state = S_INV_CHK;
            end
            S_PW_CHK: begin
                if (r_e == '0) begin
                    // accumulator is already reduced unless no multiply happened
                    n_result = (r_m == W'(1)) ? '0 : r_x;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end else if (r_e[0]) begin
                    n_state = S_PW_AMUL;
                end else begin
                    n_state = S_PW_SMUL;
                end
            end
            S_PW_AMUL: begin
                n_state = S_PW_ARED;
            end
            S_PW_ARED: begin
                n_div.start = 1'b1;
                n_num = mul_p[2*W-1:0];
                n_den = r_m;
                n_state = S_PW_AWT;
            end
            S_PW_AWT: begin
                if (div_done) begin
                    n_x = div_rem;
                    n_state = S_PW_SMUL;
                end
            end
            S_PW_SMUL: begin
                n_state = S_PW_SRED;
            end
            S_PW_SRED: begin
                n_div.start = 1'b1;
                n_num = mul_p[2*W-1:0];
                n_den = r_m;
                n_state = S_PW_SWT;
            end
            S_PW_SWT: begin
                if (div_done) begin
                    n_y = div_rem;
                    n_e = r_e >> 1;
                    n_state = S_PW_CHK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_div   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_div   <= n_div;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x      <= n_x;
        r_y      <= n_y;
        r_m      <= n_m;
        r_q      <= n_q;
        r_nr     <= n_nr;
        r_e      <= n_e;
        r_cp     <= n_cp;
        r_cc     <= n_cc;
        r_result <= n_result;
        r_num    <= n_num;
        r_den    <= n_den;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_valid;
    assign o_result       = r_result;

`ifndef NO_ASSERTIONS
    // a result always lands with the sequencer back in idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobe while busy");

    // the divider is never started with a zero divisor
    a_div_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div.start |-> (r_den != '0))
        else $error("divider started with zero divisor");

    // power reductions always come back below the modulus
    a_pow_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div_done && r_state == S_PW_AWT) |-> (div_rem < r_m))
        else $error("power reduction out of range");
`endif

endmodule

@@ bench/tb.sv @@
// Self-checking bench for modular_arithmetic_unit: gcd, inverse and power
// commands checked against an in-bench predictor. Depends on mau_pkg.
`timescale 1ns / 1ps

module tb
    import mau_pkg::*;
();

    localparam int OW = 31;
    localparam int EW = 63;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam longint CYCLE_LIMIT = 6000000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 118;

    // Holds predicted results in arrival order; one result per transfer.
    class mau_scoreboard;
        logic [OW-1:0] pending_q[$];

        function void note_transfer(logic [OW-1:0] predicted);
            pending_q = {pending_q, predicted};
        endfunction

        // Returns 1 on a match; msg explains a miss.
        function bit check_result(logic [OW-1:0] got, output string msg);
            logic [OW-1:0] want;
            if (pending_q.size() == 0) begin
                msg = $sformatf("unexpected result %0d", got);
                return 0;
            end
            want = pending_q.pop_front();
            if (got !== want) begin
                msg = $sformatf("result %0d, predicted %0d", got, want);
                return 0;
            end
            msg = "";
            return 1;
        endfunction
    endclass

    logic            i_clk;
    logic            i_rst_n;
    logic            start;
    logic            busy;
    logic [1:0]      i_command;
    logic [OW-1:0]   i_value_a;
    logic [OW-1:0]   i_value_b;
    logic [EW-1:0]   i_exponent;
    logic [OW-1:0]   i_modulus;
    logic            o_result_valid;
    logic [OW-1:0]   o_result;

    mau_scoreboard results_sb;
    int              error_count;
    longint          cycle_count;

    modular_arithmetic_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_value_a      (i_value_a),
        .i_value_b      (i_value_b),
        .i_exponent     (i_exponent),
        .i_modulus      (i_modulus),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Predictor: remainder gcd.
    function automatic longint unsigned calc_gcd(longint unsigned a, longint unsigned b);
        longint unsigned r;
        while (b != 0) begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    // Predictor: extended Euclid; non-coprime inputs keep whatever the loop leaves.
    function automatic longint unsigned calc_inverse(longint a, longint m);
        longint hi, lo, c_prev, c_cur, q, nr, nc, r;
        if (m == 0) return 0;
        hi = m;
        lo = a;
        c_prev = 0;
        c_cur = 1;
        while (lo > 0) begin
            q = hi / lo;
            nr = hi % lo;
            nc = c_prev - q * c_cur;
            hi = lo;
            lo = nr;
            c_prev = c_cur;
            c_cur = nc;
        end
        r = c_prev % m;
        if (r < 0) r += m;
        return r;
    endfunction

    // Predictor: square-and-multiply from the LSB; zero exponent gives 1 mod m.
    function automatic longint unsigned calc_power(longint unsigned base,
                                                   longint unsigned e,
                                                   longint unsigned m);
        longint unsigned acc;
        if (m == 0) return 0;
        acc = 1;
        while (e != 0) begin
            if (e[0]) acc = (acc * base) % m;
            e >>= 1;
            base = (base * base) % m;
        end
        return acc % m;
    endfunction

    function automatic logic [OW-1:0] predict_result(logic [1:0] cmd, logic [OW-1:0] a,
                                                     logic [OW-1:0] b, logic [EW-1:0] e,
                                                     logic [OW-1:0] m);
        longint unsigned res;
        case (cmd)
            CMD_GCD: res = calc_gcd(a, b);
            CMD_INV: res = calc_inverse(longint'(a), longint'(m));
            CMD_POW: res = calc_power(a, e, m);
            default: res = 0;
        endcase
        return res[OW-1:0];
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        error_count++;
    endtask

    // Drive one command at the falling edge, hold until a transfer occurs.
    // keep_start leaves start high for a back-to-back follow-up item.
    task automatic send_command(logic [1:0] cmd, logic [OW-1:0] a, logic [OW-1:0] b,
                                logic [EW-1:0] e, logic [OW-1:0] m, bit keep_start);
        @(negedge i_clk);
        start      = 1'b1;
        i_command  = cmd;
        i_value_a  = a;
        i_value_b  = b;
        i_exponent = e;
        i_modulus  = m;
        do @(posedge i_clk); while (busy);
        results_sb.note_transfer(predict_result(cmd, a, b, e, m));
        if (!keep_start) begin
            @(negedge i_clk);
            start = 1'b0;
        end
    endtask

    // Random operand: full width, small, or near the top.
    function automatic logic [OW-1:0] rand_operand();
        case ($urandom_range(0, 3))
            0:       return OW'($urandom_range(0, 40));
            1:       return {OW{1'b1}} - OW'($urandom_range(0, 40));
            default: return OW'($urandom);
        endcase
    endfunction

    // Most exponents are short; a few span the whole width.
    function automatic logic [EW-1:0] rand_exponent();
        logic [EW-1:0] e;
        e = EW'({$urandom, $urandom});
        if ($urandom_range(0, 9) < 8) e = e >> $urandom_range(EW - 16, EW - 1);
        return e;
    endfunction

    // Result monitor: every strobe is one transfer that cannot be held off.
    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n && o_result_valid) begin
            if (!results_sb.check_result(o_result, msg)) report_mismatch(msg);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        logic [1:0]    cmd;
        logic [OW-1:0] a, b, m;
        logic [EW-1:0] e;
        int            burst_left;
        int            sel;
        logic [OW-1:0] top;

        results_sb  = new();
        error_count = 0;
        cycle_count = 0;
        top         = {OW{1'b1}};
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_command   = CMD_GCD;
        i_value_a   = '0;
        i_value_b   = '0;
        i_exponent  = '0;
        i_modulus   = OW'(1);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: field extremes and the listed corner cases.
        send_command(CMD_GCD, 0, 0, 0, 1, 0);
        send_command(CMD_GCD, 12345, 0, 0, 1, 0);
        send_command(CMD_GCD, 0, top, 0, 1, 0);
        send_command(CMD_GCD, top, top, 0, 1, 0);
        send_command(CMD_GCD, 1836311903, 1134903170, 0, 1, 1);   // Fibonacci worst case
        send_command(CMD_GCD, 462, 1071, '1, top, 0);
        send_command(CMD_INV, 3, 0, 0, 7, 0);
        send_command(CMD_INV, 0, 0, 0, 13, 0);                     // inverse of zero
        send_command(CMD_INV, 6, 0, 0, 9, 0);                      // not coprime
        send_command(CMD_INV, 5, 0, 0, 0, 0);                      // zero modulus
        send_command(CMD_INV, top, top, '1, top - OW'(1), 0);
        send_command(CMD_INV, 123456, 0, 0, top, 0);
        send_command(CMD_INV, 1, 0, 0, 1, 0);
        send_command(CMD_POW, 5, 0, 0, 7, 0);                      // zero exponent
        send_command(CMD_POW, 5, 0, 0, 1, 0);                      // modulus of one
        send_command(CMD_POW, 9, 0, 100, 0, 0);                    // zero modulus
        send_command(CMD_POW, top, 0, '1, top, 0);
        send_command(CMD_POW, top - OW'(1), top, '1, top - OW'(2), 0);
        send_command(CMD_POW, 0, 0, 0, 11, 0);
        send_command(CMD_POW, 2, 0, {1'b1, {(EW - 1){1'b0}}}, 1000003, 0);
        send_command(CMD_UNUSED, top, top, '1, top, 0);            // unused command
        send_command(CMD_UNUSED, 0, 0, 0, 0, 0);

        // Random part: bursts of back-to-back commands, gaps in between.
        burst_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            sel = $urandom_range(0, 19);
            cmd = (sel == 0) ? CMD_UNUSED : 2'($urandom_range(0, 2));
            a   = rand_operand();
            b   = rand_operand();
            e   = rand_exponent();
            m   = ($urandom_range(0, 29) == 0) ? '0 : rand_operand();
            if (m == 0 && $urandom_range(0, 1)) m = OW'(1);
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 8);
                repeat ($urandom_range(0, 30)) @(negedge i_clk);
            end
            burst_left--;
            send_command(cmd, a, b, e, m, burst_left != 0 && n != RANDOM_ITEMS - 1);
        end

        while (results_sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
